// ===== src/assert_macros.svh =====
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("property violated");

// Property checked on every clock edge, reset included.
`define ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("property violated");

`endif

// ===== src/fqs_pkg.sv =====
// Shared types and constants of the Q15 saturating FIR filter.
package fqs_pkg;

    // Default number of filter taps.
    localparam int TAPS_DEF = 21;

    // Field and datapath widths.
    localparam int SAMPLE_W  = 16;
    localparam int IDX_W     = 5;
    localparam int ACC_W     = 32;
    // Wide enough to compare a slot number against any legal tap count.
    localparam int IDX_CMP_W = 7;

    // Item modes.
    localparam logic MODE_FILTER = 1'b0;
    localparam logic MODE_COEFF  = 1'b1;

    // Saturation limits.
    localparam logic signed [SAMPLE_W-1:0] Q15_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] Q15_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0]    Q31_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0]    Q31_MAX = {1'b0, {(ACC_W-1){1'b1}}};

    // Control of the shared multiply-accumulate unit.
    typedef struct packed {
        logic clear;  // start a new sum
        logic valid;  // operands present this cycle
        logic last;   // operands belong to the final tap
    } t_mac_ctl;

endpackage

// ===== src/fqs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fqs_ram #(
    parameter int WIDTH = fqs_pkg::SAMPLE_W,
    parameter int DEPTH = fqs_pkg::TAPS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/fqs_mac.sv =====
// Shared saturating Q15 multiply with saturating 32-bit accumulate.
module fqs_mac (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fqs_pkg::t_mac_ctl                   i_ctl,
    input  logic signed [fqs_pkg::SAMPLE_W-1:0] i_a,
    input  logic signed [fqs_pkg::SAMPLE_W-1:0] i_b,
    output logic signed [fqs_pkg::ACC_W-1:0]    o_acc,
    output logic                                o_done
);
    import fqs_pkg::*;

    logic signed [2*SAMPLE_W-1:0] w_prod;
    logic signed [ACC_W-1:0]      n_prod;
    logic signed [ACC_W:0]        w_sum;
    logic signed [ACC_W-1:0]      n_acc;

    logic signed [ACC_W-1:0] r_prod;
    logic                    r_prod_v;
    logic                    r_prod_last;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_done;

    // Fractional product: doubled, with minus one squared clipped to full scale.
    assign w_prod = i_a * i_b;
    always_comb begin
        if (i_a == Q15_MIN && i_b == Q15_MIN) begin
            n_prod = Q31_MAX;
        end else begin
            n_prod = {w_prod[2*SAMPLE_W-2:0], 1'b0};
        end
    end

    // Accumulate with saturation to the signed 32-bit range.
    assign w_sum = {r_acc[ACC_W-1], r_acc} + {r_prod[ACC_W-1], r_prod};
    always_comb begin
        if (w_sum[ACC_W] != w_sum[ACC_W-1]) begin
            n_acc = w_sum[ACC_W] ? Q31_MIN : Q31_MAX;
        end else begin
            n_acc = w_sum[ACC_W-1:0];
        end
    end

    // Product register, then accumulator register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v    <= 1'b0;
            r_prod_last <= 1'b0;
            r_acc       <= '0;
            r_done      <= 1'b0;
        end else if (i_ctl.clear) begin
            r_prod_v    <= 1'b0;
            r_prod_last <= 1'b0;
            r_acc       <= '0;
            r_done      <= 1'b0;
        end else begin
            r_prod_v    <= i_ctl.valid;
            r_prod_last <= i_ctl.valid && i_ctl.last;
            if (r_prod_v) begin
                r_acc <= n_acc;
            end
            r_done <= r_prod_v && r_prod_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

// ===== src/fir_filter_q15_saturating.sv =====
// Top level of the Q15 saturating FIR filter with a circular delay line.
// A sample word (mode 0) is stored as the newest entry of the delay line and starts a filter
// pass: one shared multiply-accumulate unit walks the taps oldest-first, one tap per cycle,
// and the saturated sum is rounded to 1.15 and presented on o_filtered. After a sample word,
// o_ready stays low through the run, drain and finish states, as each tap passes the store
// read registers and the product and accumulate registers of the single multiply-accumulate
// unit; it stays low longer while a previous result still waits in the output register. A
// coefficient word (mode 1) leaves o_ready high, gives no result, and is ignored when its
// slot is not below TAPS. Both stores read as zero after reset until written.
module fir_filter_q15_saturating #(
    parameter int TAPS = fqs_pkg::TAPS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_mode,
    input  logic [fqs_pkg::IDX_W-1:0]           i_coeff_index,
    input  logic signed [fqs_pkg::SAMPLE_W-1:0] i_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [fqs_pkg::SAMPLE_W-1:0] o_filtered
);
    import fqs_pkg::*;

    localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_FINISH} t_state;

    t_state                      r_state;
    logic [AW-1:0]               r_wptr;
    logic [AW-1:0]               r_pos;
    logic [AW-1:0]               r_k;
    logic [TAPS-1:0]             r_s_vld;
    logic [TAPS-1:0]             r_c_vld;
    logic                        r_rd_v;
    logic                        r_rd_last;
    logic                        r_s_rv;
    logic                        r_c_rv;
    logic                        r_o_valid;
    logic signed [SAMPLE_W-1:0]  r_o_filtered;

    logic                        w_in_acc;
    logic                        w_smp_we;
    logic                        w_coef_we;
    logic [AW-1:0]               w_coef_addr;
    logic [AW-1:0]               n_wptr;
    logic [SAMPLE_W-1:0]         w_s_rdata;
    logic [SAMPLE_W-1:0]         w_c_rdata;
    logic signed [SAMPLE_W-1:0]  w_mac_a;
    logic signed [SAMPLE_W-1:0]  w_mac_b;
    t_mac_ctl                    w_mac_ctl;
    logic signed [ACC_W-1:0]     w_acc;
    logic                        w_mac_done;
    logic signed [ACC_W:0]       w_rnd;
    logic signed [SAMPLE_W-1:0]  w_result;
    logic                        w_out_free;

    // Advance a delay-line position with wrap at the last tap.
    function automatic logic [AW-1:0] f_wrap_inc(input logic [AW-1:0] p);
        logic [AW-1:0] q;
        q = (p == LAST) ? '0 : p + 1'b1;
        return q;
    endfunction

    // Input handshake and store writes.
    assign o_ready     = (r_state == S_IDLE);
    assign w_in_acc    = i_valid && o_ready;
    assign w_smp_we    = w_in_acc && (i_mode == MODE_FILTER);
    assign w_coef_we   = w_in_acc && (i_mode == MODE_COEFF)
                         && (IDX_CMP_W'(i_coeff_index) < IDX_CMP_W'(TAPS));
    assign w_coef_addr = AW'(i_coeff_index);
    assign n_wptr      = f_wrap_inc(r_wptr);

    fqs_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TAPS)
    ) u_smp_ram (
        .i_clk   (i_clk),
        .i_we    (w_smp_we),
        .i_waddr (r_wptr),
        .i_wdata (i_value),
        .i_raddr (r_pos),
        .o_rdata (w_s_rdata)
    );

    fqs_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TAPS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (w_coef_addr),
        .i_wdata (i_value),
        .i_raddr (r_k),
        .o_rdata (w_c_rdata)
    );

    // Entries never written read as zero.
    assign w_mac_a = r_s_rv ? signed'(w_s_rdata) : '0;
    assign w_mac_b = r_c_rv ? signed'(w_c_rdata) : '0;

    assign w_mac_ctl.clear = w_smp_we;
    assign w_mac_ctl.valid = r_rd_v;
    assign w_mac_ctl.last  = r_rd_last;

    fqs_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_a     (w_mac_a),
        .i_b     (w_mac_b),
        .o_acc   (w_acc),
        .o_done  (w_mac_done)
    );

    // Round to 1.15: add one half LSB, keep the upper half, clip positive overflow.
    assign w_rnd = {w_acc[ACC_W-1], w_acc} + (ACC_W+1)'(1 << (SAMPLE_W - 1));
    always_comb begin
        if (!w_rnd[ACC_W] && w_rnd[ACC_W-1]) begin
            w_result = Q15_MAX;
        end else begin
            w_result = w_rnd[ACC_W-1:ACC_W-SAMPLE_W];
        end
    end

    assign w_out_free = !r_o_valid || i_ready;

    // Sequencer, store valid bits and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wptr    <= '0;
            r_pos     <= '0;
            r_k       <= '0;
            r_s_vld   <= '0;
            r_c_vld   <= '0;
            r_rd_v    <= 1'b0;
            r_rd_last <= 1'b0;
            r_s_rv    <= 1'b0;
            r_c_rv    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_rd_v    <= (r_state == S_RUN);
            r_rd_last <= (r_state == S_RUN) && (r_k == LAST);
            r_s_rv    <= r_s_vld[r_pos];
            r_c_rv    <= r_c_vld[r_k];

            if (r_o_valid && i_ready && (r_state != S_FINISH)) begin
                r_o_valid <= 1'b0;
            end
            if (w_coef_we) begin
                r_c_vld[w_coef_addr] <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_smp_we) begin
                        r_s_vld[r_wptr] <= 1'b1;
                        r_wptr          <= n_wptr;
                        r_pos           <= n_wptr;
                        r_k             <= '0;
                        r_state         <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_pos <= f_wrap_inc(r_pos);
                    r_k   <= r_k + 1'b1;
                    if (r_k == LAST) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (w_mac_done) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_o_valid    <= 1'b1;
                        r_o_filtered <= w_result;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid    = r_o_valid;
    assign o_filtered = r_o_filtered;

endmodule

// ===== src/fqs_checker.sv =====
// Port-level checker for the Q15 saturating FIR filter, bound to its top level.
`include "assert_macros.svh"

module fqs_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_ready,
    input logic                                i_mode,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic signed [fqs_pkg::SAMPLE_W-1:0] o_filtered
);
    import fqs_pkg::*;

    // A result word waiting for the sink stays put.
    `ASSERT_CLK_RST(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_filtered))

    // A sample word makes the block busy for its filter pass.
    `ASSERT_CLK_RST(a_busy_after_sample, i_clk, i_rst_n, i_valid && o_ready && i_mode == MODE_FILTER |=> !o_ready)

    // A result appears only at the end of a filter pass, never straight from idle.
    `ASSERT_CLK_RST(a_result_from_pass, i_clk, i_rst_n, $rose(o_valid) |-> $past(!o_ready))

    // Reset leaves no result word pending.
    `ASSERT_CLK(a_reset_clears_out, i_clk, !i_rst_n |=> !o_valid)

endmodule

bind fir_filter_q15_saturating fqs_checker u_fqs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .i_mode     (i_mode),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_filtered (o_filtered)
);
